// File: design/wcpa_pkg.sv
// ============================================================================
// wcpa_pkg: shared types and constants for the weighted cross product accumulator
// Holds the item structs, the op codes, the register indexes and the structs
// passed between the row feed, the column cells and the top level.
// ============================================================================
package wcpa_pkg;

    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    // Index width that covers the largest table dimension (64)
    localparam int DIM_W  = 6;
    localparam int VAL_W  = 16;
    localparam int ACC_W  = 64;
    localparam int DW_W   = 33;   // (x - c) * w, signed
    localparam int TERM_W = 49;   // (x - c) * w * y, signed

    localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [2:0] OP_LOAD_X = 3'd0;
    localparam logic [2:0] OP_LOAD_Y = 3'd1;
    localparam logic [2:0] OP_LOAD_C = 3'd2;
    localparam logic [2:0] OP_COMMIT = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd2;

    typedef struct packed {
        logic [2:0]              op;
        logic [2:0]              row_index;
        logic [2:0]              col_index;
        logic signed [VAL_W-1:0] element_value;
        logic [15:0]             weight;
    } cmd_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_value;
        logic                    saturated;
    } result_t;

    // Row term travelling down the cell chain
    typedef struct packed {
        logic                   valid;
        logic [DIM_W-1:0]       row;
        logic signed [DW_W-1:0] dw;
    } token_t;

    // Row feed control from the top level
    typedef struct packed {
        logic                    x_we;
        logic                    c_we;
        logic [DIM_W-1:0]        wr_addr;
        logic signed [VAL_W-1:0] wr_val;
        logic                    go;
        logic [DIM_W:0]          rows;
        logic [15:0]             weight;
        logic                    center_en;
    } feed_ctl_t;

    // Broadcast control to every column cell
    typedef struct packed {
        logic                    clr_en;
        logic [DIM_W-1:0]        addr;
        logic                    y_we;
        logic [DIM_W-1:0]        y_col;
        logic signed [VAL_W-1:0] y_val;
    } cell_ctl_t;

    typedef struct packed {
        logic busy;
        logic sat;
    } cell_stat_t;

endpackage

// File: design/wcpa_row_feed.sv
// ============================================================================
// wcpa_row_feed: row sequencer for a commit
// Holds the x and center vectors, walks the rows in use one per cycle and
// sends (x - c) * w (x * w, centering off) per row into the cell chain head.
// ============================================================================
module wcpa_row_feed #(
    parameter int MAX_ROWS = wcpa_pkg::MAX_ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wcpa_pkg::feed_ctl_t ctl,
    output wcpa_pkg::token_t    tok,
    output logic                busy
);

    localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DW = wcpa_pkg::DIM_W;
    localparam int VW = wcpa_pkg::VAL_W;

    logic signed [VW-1:0] x_mem [MAX_ROWS];
    logic signed [VW-1:0] c_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]  x_vld_reg;
    logic [MAX_ROWS-1:0]  c_vld_reg;

    logic                 issue_reg;
    logic [DW:0]          cnt_reg;
    logic [DW:0]          rows_reg;
    logic [15:0]          w_reg;
    logic                 cen_reg;

    logic                 s1_valid_reg;
    logic [DW-1:0]        s1_row_reg;
    logic signed [VW-1:0] s1_x_reg;
    logic signed [VW-1:0] s1_c_reg;

    logic                 s2_valid_reg;
    logic [DW-1:0]        s2_row_reg;
    logic signed [wcpa_pkg::DW_W-1:0] dw_reg;

    logic [RA-1:0]        wr_idx;
    logic [RA-1:0]        rd_idx;
    logic signed [VW:0]   diff;
    logic signed [VW:0]   w_ext;
    logic signed [2*VW+1:0] prod;

    assign wr_idx = ctl.wr_addr[RA-1:0];
    assign rd_idx = cnt_reg[RA-1:0];

    // x and center stores; entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (ctl.x_we)
        begin
            x_mem[wr_idx] <= ctl.wr_val;
        end
        if (ctl.c_we)
        begin
            c_mem[wr_idx] <= ctl.wr_val;
        end
        s1_x_reg <= x_vld_reg[rd_idx] ? x_mem[rd_idx] : '0;
        s1_c_reg <= c_vld_reg[rd_idx] ? c_mem[rd_idx] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg <= '0;
            c_vld_reg <= '0;
        end
        else
        begin
            if (ctl.x_we)
            begin
                x_vld_reg[wr_idx] <= 1'b1;
            end
            if (ctl.c_we)
            begin
                c_vld_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            cnt_reg      <= '0;
            rows_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.go)
            begin
                issue_reg <= (ctl.rows != '0);
                cnt_reg   <= '0;
                rows_reg  <= ctl.rows;
            end
            else if (issue_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == rows_reg)
                begin
                    issue_reg <= 1'b0;
                end
            end
            s1_valid_reg <= issue_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign diff  = {s1_x_reg[VW-1], s1_x_reg}
                 - (cen_reg ? {s1_c_reg[VW-1], s1_c_reg} : '0);
    assign w_ext = {1'b0, w_reg};
    assign prod  = diff * w_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.go)
        begin
            w_reg   <= ctl.weight;
            cen_reg <= ctl.center_en;
        end
        s1_row_reg <= cnt_reg[DW-1:0];
        s2_row_reg <= s1_row_reg;
        dw_reg     <= prod[wcpa_pkg::DW_W-1:0];
    end

    always_comb
    begin
        tok.valid = s2_valid_reg;
        tok.row   = s2_row_reg;
        tok.dw    = dw_reg;
    end

    assign busy = issue_reg | s1_valid_reg | s2_valid_reg;

endmodule

// File: design/wcpa_cell.sv
// ============================================================================
// wcpa_cell: one accumulator column
// Holds y[k] and the column's accumulators. Each row term from the left is
// multiplied by y[k], saturating-added if enabled and passed on to the right.
// ============================================================================
module wcpa_cell #(
    parameter int MAX_ROWS = wcpa_pkg::MAX_ROWS_DEF,
    parameter int COL_ID   = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wcpa_pkg::cell_ctl_t            ctl,
    input  logic                           enable,
    input  wcpa_pkg::token_t               tok_in,
    output wcpa_pkg::token_t               tok_out,
    output logic signed [wcpa_pkg::ACC_W-1:0] rd_data,
    output wcpa_pkg::cell_stat_t           stat
);

    localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = wcpa_pkg::ACC_W;
    localparam int TW = wcpa_pkg::TERM_W;

    logic signed [wcpa_pkg::VAL_W-1:0] y_reg;
    logic signed [AW-1:0]  acc_mem [MAX_ROWS];
    logic signed [AW-1:0]  rd_data_reg;
    wcpa_pkg::token_t      tok_reg;

    logic                  a_valid_reg;
    logic [RA-1:0]         a_row_reg;
    logic signed [TW-1:0]  a_prod_reg;

    logic [RA-1:0]         rd_idx;
    logic signed [TW-1:0]  prod;
    logic [AW:0]           sum;
    logic                  ovf;
    logic signed [AW-1:0]  wr_value;

    assign rd_idx = tok_in.valid ? tok_in.row[RA-1:0] : ctl.addr[RA-1:0];
    assign prod   = tok_in.dw * y_reg;

    // Saturating add: overflow when the two top bits of the 65-bit sum differ
    assign sum = {rd_data_reg[AW-1], rd_data_reg} + {{(AW+1-TW){a_prod_reg[TW-1]}}, a_prod_reg};
    assign ovf = sum[AW] ^ sum[AW-1];

    always_comb
    begin
        if (!ovf)
        begin
            wr_value = sum[AW-1:0];
        end
        else if (sum[AW])
        begin
            wr_value = wcpa_pkg::ACC_MIN;
        end
        else
        begin
            wr_value = wcpa_pkg::ACC_MAX;
        end
    end

    // Clear pass and read-modify-write never overlap
    always_ff @(posedge clk)
    begin
        if (ctl.clr_en)
        begin
            acc_mem[ctl.addr[RA-1:0]] <= '0;
        end
        else if (a_valid_reg)
        begin
            acc_mem[a_row_reg] <= wr_value;
        end
        rd_data_reg <= acc_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        a_row_reg  <= tok_in.row[RA-1:0];
        a_prod_reg <= prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg       <= '0;
            tok_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.y_we && ctl.y_col == wcpa_pkg::DIM_W'(COL_ID))
            begin
                y_reg <= ctl.y_val;
            end
            tok_reg     <= tok_in;
            a_valid_reg <= tok_in.valid & enable;
        end
    end

    assign tok_out   = tok_reg;
    assign rd_data   = rd_data_reg;
    assign stat.busy = tok_in.valid | a_valid_reg;
    assign stat.sat  = a_valid_reg & ovf;

endmodule

// File: design/weighted_cross_product_accumulator.sv
// ============================================================================
// weighted_cross_product_accumulator: top level
// Accumulates sum_i w_i (x_i - c) y_i^T into a MAX_ROWS by MAX_COLS table of
// saturating Q48.16 accumulators, one column cell per y element.
// ============================================================================
//
//  channel   handshake                 payload        notes
//  -------   -----------------------   ------------   ------------------------
//  command   start & !busy             cmd (cmd_t)    loads, commit, read, clear
//  result    result_valid (1 cycle)    result         only a read gives one
//  config    cfg_we                    cfg_index/data write only, no wait
//
//  Loads and unused ops leave the block idle; busy stays low.
//  Read: the FSM passes ST_READ and ST_REPLY; result_valid and the result
//  are registered from ST_REPLY. Commit: busy holds until the row walk and the
//  hop through every column cell drain. Clear: ST_CLEAR zeroes every table row.
//  After reset the table is swept to zero with busy high.
//  The result side has no stall: each result is shown for one cycle.
//
module weighted_cross_product_accumulator #(
    parameter int MAX_ROWS = wcpa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = wcpa_pkg::MAX_COLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  wcpa_pkg::cmd_t                      cmd,
    output logic                                busy,
    output logic                                result_valid,
    output wcpa_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [wcpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wcpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DW = wcpa_pkg::DIM_W;
    localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_COMMIT = 5'b00100,
        ST_READ   = 5'b01000,
        ST_REPLY  = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [DW-1:0]      clr_cnt_reg;
    logic [DW-1:0]      clr_cnt_next;
    logic [3:0]         rows_reg;
    logic [3:0]         cols_reg;
    logic               center_reg;
    logic               sat_reg;
    logic [2:0]         rd_row_reg;
    logic [2:0]         rd_col_reg;
    logic               result_valid_reg;
    wcpa_pkg::result_t  result_reg;

    logic               accept;
    logic               row_ok;
    logic               col_ok;
    logic               rd_in_range;
    logic [DW:0]        rows_eff;
    logic [DW:0]        cols_eff;
    logic               pipe_busy;
    logic               feed_busy;
    logic               any_sat;
    logic [CA-1:0]      rd_sel;

    wcpa_pkg::feed_ctl_t  feed_ctl;
    wcpa_pkg::cell_ctl_t  cell_ctl;
    wcpa_pkg::token_t     tok [MAX_COLS+1];
    wcpa_pkg::cell_stat_t stat [MAX_COLS];
    logic signed [wcpa_pkg::ACC_W-1:0] rd_data [MAX_COLS];
    logic [MAX_COLS-1:0]  cell_en;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign row_ok = ((DW+1)'(cmd.row_index) < (DW+1)'(MAX_ROWS));
    assign col_ok = ((DW+1)'(cmd.col_index) < (DW+1)'(MAX_COLS));
    assign rd_in_range = ((DW+1)'(rd_row_reg) < (DW+1)'(MAX_ROWS))
                      && ((DW+1)'(rd_col_reg) < (DW+1)'(MAX_COLS));

    // Sizes above the table dimension clip to it
    assign rows_eff = ((DW+1)'(rows_reg) > (DW+1)'(MAX_ROWS)) ? (DW+1)'(MAX_ROWS)
                                                                : (DW+1)'(rows_reg);
    assign cols_eff = ((DW+1)'(cols_reg) > (DW+1)'(MAX_COLS)) ? (DW+1)'(MAX_COLS)
                                                                : (DW+1)'(cols_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= 4'd8;
            cols_reg   <= 4'd8;
            center_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wcpa_pkg::CFG_ROWS:   rows_reg   <= cfg_data;
                wcpa_pkg::CFG_COLS:   cols_reg   <= cfg_data;
                wcpa_pkg::CFG_CENTER: center_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        feed_ctl.x_we      = accept && (cmd.op == wcpa_pkg::OP_LOAD_X) && row_ok;
        feed_ctl.c_we      = accept && (cmd.op == wcpa_pkg::OP_LOAD_C) && row_ok;
        feed_ctl.wr_addr   = DW'(cmd.row_index);
        feed_ctl.wr_val    = cmd.element_value;
        feed_ctl.go        = accept && (cmd.op == wcpa_pkg::OP_COMMIT);
        feed_ctl.rows      = rows_eff;
        feed_ctl.weight    = cmd.weight;
        feed_ctl.center_en = center_reg;

        cell_ctl.clr_en = (state_reg == ST_CLEAR);
        cell_ctl.addr   = (state_reg == ST_READ) ? DW'(rd_row_reg) : clr_cnt_reg;
        cell_ctl.y_we   = accept && (cmd.op == wcpa_pkg::OP_LOAD_Y) && col_ok;
        cell_ctl.y_col  = DW'(cmd.col_index);
        cell_ctl.y_val  = cmd.element_value;
    end

    wcpa_row_feed #(
        .MAX_ROWS (MAX_ROWS)
    ) u_feed (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (feed_ctl),
        .tok   (tok[0]),
        .busy  (feed_busy)
    );

    for (genvar k = 0; k < MAX_COLS; k++)
    begin : g_cell
        assign cell_en[k] = (cols_eff > (DW+1)'(k));

        wcpa_cell #(
            .MAX_ROWS (MAX_ROWS),
            .COL_ID   (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl),
            .enable  (cell_en[k]),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1]),
            .rd_data (rd_data[k]),
            .stat    (stat[k])
        );
    end

    always_comb
    begin
        pipe_busy = feed_busy | tok[MAX_COLS].valid;
        any_sat   = 1'b0;
        for (int k = 0; k < MAX_COLS; k++)
        begin
            pipe_busy = pipe_busy | stat[k].busy;
            any_sat   = any_sat | stat[k].sat;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        wcpa_pkg::OP_COMMIT: state_next = ST_COMMIT;
                        wcpa_pkg::OP_READ:   state_next = ST_READ;
                        wcpa_pkg::OP_CLEAR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_cnt_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == DW'(MAX_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMMIT:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:  state_next = ST_REPLY;
            ST_REPLY: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= (state_reg == ST_REPLY);
            if (accept && (cmd.op == wcpa_pkg::OP_CLEAR))
            begin
                sat_reg <= 1'b0;
            end
            else if (any_sat)
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    assign rd_sel = CA'(rd_col_reg);

    always_ff @(posedge clk)
    begin
        if (accept && (cmd.op == wcpa_pkg::OP_READ))
        begin
            rd_row_reg <= cmd.row_index;
            rd_col_reg <= cmd.col_index;
        end
        if (state_reg == ST_REPLY)
        begin
            result_reg.acc_value <= rd_in_range ? rd_data[rd_sel] : '0;
            result_reg.saturated <= sat_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result only follows the reply cycle
    a_result_after_reply: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg == ST_REPLY))
        else $error("result strobe without a reply cycle");

    // Idle means the row feed and every cell have drained
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("idle while commit terms are still in flight");

    // The clearing sweep never meets a row term
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctl.clr_en |-> !pipe_busy)
        else $error("clear pass overlaps a commit");

    // A clear item drops the sticky flag
    a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == wcpa_pkg::OP_CLEAR)) |=> !sat_reg)
        else $error("saturation flag survived a clear");

endmodule

// File: tb/weighted_cross_product_accumulator_tb.sv
// ============================================================================
// weighted_cross_product_accumulator_tb: self-checking bench for the top level
// Drives load, commit, read and clear items through the start/busy port,
// tracks the accumulator table in a scoreboard and checks every read result
// field by field. It runs across several register settings, an extreme-value
// run and random observation sequences, with random idle cycles on the sender.
// ============================================================================
module weighted_cross_product_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [wcpa_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int ITEMS_PER_PHASE = 48;
    localparam int EXTREME_COMMITS = 24;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 4000000;
    localparam int NUM_PHASES      = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the stores, the table and the registers
    // ------------------------------------------------------------------------
    class accumulator_scoreboard;
        logic signed [wcpa_pkg::VAL_W-1:0] x_row [wcpa_pkg::MAX_ROWS_DEF];
        logic signed [wcpa_pkg::VAL_W-1:0] y_col [wcpa_pkg::MAX_COLS_DEF];
        logic signed [wcpa_pkg::VAL_W-1:0] ctr_row [wcpa_pkg::MAX_ROWS_DEF];
        longint                  acc [wcpa_pkg::MAX_ROWS_DEF][wcpa_pkg::MAX_COLS_DEF];
        bit                      sat;
        logic [3:0]              rows_cfg;
        logic [3:0]              cols_cfg;
        bit                      ctr_en;
        wcpa_pkg::result_t       reads_q [$];
        int                      errors;

        function new();
            rows_cfg = 4'd8;
            cols_cfg = 4'd8;
            ctr_en   = 1'b0;
            sat      = 1'b0;
            errors   = 0;
            for (int r = 0; r < wcpa_pkg::MAX_ROWS_DEF; r++)
            begin
                x_row[r]   = '0;
                ctr_row[r] = '0;
                for (int k = 0; k < wcpa_pkg::MAX_COLS_DEF; k++)
                    acc[r][k] = 0;
            end
            for (int k = 0; k < wcpa_pkg::MAX_COLS_DEF; k++)
                y_col[k] = '0;
        endfunction

        function void set_reg(logic [wcpa_pkg::CFG_IDX_W-1:0] idx,
                              logic [wcpa_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                wcpa_pkg::CFG_ROWS:   rows_cfg = data;
                wcpa_pkg::CFG_COLS:   cols_cfg = data;
                wcpa_pkg::CFG_CENTER: ctr_en   = data[0];
                default:    ;
            endcase
        endfunction

        function int pending();
            return reads_q.size();
        endfunction

        function void fold_row(logic [15:0] w);
            int     nr;
            int     nc;
            longint d;
            longint wl;
            longint dw;
            longint term;
            longint sum;
            nr = (rows_cfg > wcpa_pkg::MAX_ROWS_DEF) ? wcpa_pkg::MAX_ROWS_DEF : int'(rows_cfg);
            nc = (cols_cfg > wcpa_pkg::MAX_COLS_DEF) ? wcpa_pkg::MAX_COLS_DEF : int'(cols_cfg);
            wl = w;
            for (int r = 0; r < nr; r++)
            begin
                d = x_row[r];
                if (ctr_en)
                    d = d - ctr_row[r];
                dw = d * wl;
                for (int k = 0; k < nc; k++)
                begin
                    term = dw * y_col[k];
                    sum  = acc[r][k] + term;
                    // wrap in the 64-bit add means the true sum left the range
                    if (term > 0 && sum < acc[r][k])
                    begin
                        sum = wcpa_pkg::ACC_MAX;
                        sat = 1'b1;
                    end
                    else if (term < 0 && sum > acc[r][k])
                    begin
                        sum = wcpa_pkg::ACC_MIN;
                        sat = 1'b1;
                    end
                    acc[r][k] = sum;
                end
            end
        endfunction

        function void note(wcpa_pkg::cmd_t c);
            wcpa_pkg::result_t e;
            case (c.op)
                wcpa_pkg::OP_LOAD_X: x_row[c.row_index]   = c.element_value;
                wcpa_pkg::OP_LOAD_Y: y_col[c.col_index]   = c.element_value;
                wcpa_pkg::OP_LOAD_C: ctr_row[c.row_index] = c.element_value;
                wcpa_pkg::OP_COMMIT: fold_row(c.weight);
                wcpa_pkg::OP_READ:
                begin
                    e.acc_value = acc[c.row_index][c.col_index];
                    e.saturated = sat;
                    reads_q.push_back(e);
                end
                wcpa_pkg::OP_CLEAR:
                begin
                    for (int r = 0; r < wcpa_pkg::MAX_ROWS_DEF; r++)
                        for (int k = 0; k < wcpa_pkg::MAX_COLS_DEF; k++)
                            acc[r][k] = 0;
                    sat = 1'b0;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        endtask

        task check(wcpa_pkg::result_t r);
            wcpa_pkg::result_t e;
            if (reads_q.size() == 0)
            begin
                report_mismatch("result with no read pending", r.acc_value, 64'd0);
            end
            else
            begin
                e = reads_q.pop_front();
                if (r.acc_value !== e.acc_value)
                    report_mismatch("acc_value", r.acc_value, e.acc_value);
                if (r.saturated !== e.saturated)
                    report_mismatch("saturated", 64'(r.saturated), 64'(e.saturated));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 start;
    wcpa_pkg::cmd_t                       cmd;
    logic                                 busy;
    logic                                 result_valid;
    wcpa_pkg::result_t                    result;
    logic                                 cfg_we;
    logic [wcpa_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [wcpa_pkg::CFG_DATA_W-1:0]      cfg_data;

    accumulator_scoreboard sb = new();
    bit                    idle_on = 1'b1;
    int                    items_sent = 0;
    int                    cycle_count = 0;

    weighted_cross_product_accumulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // results first: a result at this edge belongs to an earlier read
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check(result);
            if (start && !busy)
                sb.note(cmd);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic wcpa_pkg::cmd_t mk(logic [2:0] op, logic [2:0] ri, logic [2:0] ci,
                                          logic [15:0] v, logic [15:0] w);
        wcpa_pkg::cmd_t c;
        c.op            = op;
        c.row_index     = ri;
        c.col_index     = ci;
        c.element_value = v;
        c.weight        = w;
        return c;
    endfunction

    function automatic logic [15:0] rand_val();
        logic [15:0] v;
        case ($urandom_range(19))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'h0000;
            3:       v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_weight();
        logic [15:0] w;
        case ($urandom_range(9))
            0:       w = 16'h0000;
            1:       w = 16'hFFFF;
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic send(wcpa_pkg::cmd_t c);
        while (idle_on && $urandom_range(99) < 18)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // drop start, let every read come back and the last commit drain
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [wcpa_pkg::CFG_IDX_W-1:0] idx,
                             logic [wcpa_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // one observation: x row, y row, maybe a center, commit, a few reads
    task automatic run_observation();
        int nx;
        int ny;
        int nreads;
        nx = $urandom_range(1, wcpa_pkg::MAX_ROWS_DEF);
        ny = $urandom_range(1, wcpa_pkg::MAX_COLS_DEF);
        for (int r = 0; r < nx; r++)
            send(mk(wcpa_pkg::OP_LOAD_X, 3'(r), 3'($urandom), rand_val(), 16'($urandom)));
        for (int k = 0; k < ny; k++)
            send(mk(wcpa_pkg::OP_LOAD_Y, 3'($urandom), 3'(k), rand_val(), 16'($urandom)));
        if ($urandom_range(2) == 0)
            for (int r = 0; r < nx; r++)
                send(mk(wcpa_pkg::OP_LOAD_C, 3'(r), 3'($urandom), rand_val(),
                        16'($urandom)));
        send(mk(wcpa_pkg::OP_COMMIT, 3'($urandom), 3'($urandom), 16'($urandom),
                rand_weight()));
        nreads = $urandom_range(1, 3);
        for (int i = 0; i < nreads; i++)
        begin
            if ($urandom_range(9) < 7)
                send(mk(wcpa_pkg::OP_READ, 3'($urandom_range(0, nx - 1)),
                        3'($urandom_range(0, ny - 1)), 16'($urandom), 16'($urandom)));
            else
                send(mk(wcpa_pkg::OP_READ, 3'($urandom), 3'($urandom), 16'($urandom),
                        16'($urandom)));
        end
        if ($urandom_range(19) == 0)
            send(mk(wcpa_pkg::OP_CLEAR, 3'($urandom), 3'($urandom), 16'($urandom),
                    16'($urandom)));
    endtask

    task automatic run_random(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(3) != 0)
                run_observation();
            else
                send(mk(3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom),
                        16'($urandom)));
        end
    endtask

    // pile the largest terms of both signs into one row, then reload one y entry
    task automatic run_extremes();
        idle_on = 1'b0;
        write_reg(wcpa_pkg::CFG_ROWS, 4'd1);
        write_reg(wcpa_pkg::CFG_COLS, 4'd8);
        write_reg(wcpa_pkg::CFG_CENTER, 4'd1);
        send(mk(wcpa_pkg::OP_LOAD_X, 3'd0, 3'd0, 16'h7FFF, 16'd0));
        send(mk(wcpa_pkg::OP_LOAD_C, 3'd0, 3'd0, 16'h8000, 16'd0));
        for (int k = 0; k < wcpa_pkg::MAX_COLS_DEF; k++)
            send(mk(wcpa_pkg::OP_LOAD_Y, 3'd0, 3'(k), (k % 2 == 0) ? 16'h8000 : 16'h7FFF,
                    16'd0));
        send(mk(wcpa_pkg::OP_CLEAR, 3'd0, 3'd0, 16'd0, 16'd0));
        for (int i = 0; i < EXTREME_COMMITS; i++)
            send(mk(wcpa_pkg::OP_COMMIT, 3'd0, 3'd0, 16'd0, 16'hFFFF));
        for (int k = 0; k < wcpa_pkg::MAX_COLS_DEF; k++)
            send(mk(wcpa_pkg::OP_READ, 3'd0, 3'(k), 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_LOAD_Y, 3'd0, 3'd0, 16'h7FFF, 16'd0));
        send(mk(wcpa_pkg::OP_COMMIT, 3'd0, 3'd0, 16'd0, 16'd1));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd0, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd1, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_READ, 3'd5, 3'd3, 16'd0, 16'd0));
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    logic [3:0] phase_rows [NUM_PHASES] = '{4'd8, 4'd1, 4'd0, 4'd3, 4'd15,
                                             4'd9, 4'd5, 4'd8, 4'd0, 4'd0};
    logic [3:0] phase_cols [NUM_PHASES] = '{4'd8, 4'd1, 4'd5, 4'd0, 4'd15,
                                             4'd2, 4'd8, 4'd1, 4'd0, 4'd0};
    logic [3:0] phase_ctr  [NUM_PHASES] = '{4'd0, 4'd1, 4'd1, 4'd0, 4'hF,
                                             4'hE, 4'd1, 4'd3, 4'd0, 4'd0};

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // table sweep after reset
        while (busy)
            @(posedge clk);

        // directed: extremes at reset sizes
        send(mk(wcpa_pkg::OP_LOAD_X, 3'd0, 3'd0, 16'h7FFF, 16'd0));
        send(mk(wcpa_pkg::OP_LOAD_X, 3'd7, 3'd7, 16'h8000, 16'hFFFF));
        send(mk(wcpa_pkg::OP_LOAD_Y, 3'd7, 3'd0, 16'h8000, 16'd0));
        send(mk(wcpa_pkg::OP_LOAD_Y, 3'd0, 3'd7, 16'h7FFF, 16'hFFFF));
        send(mk(wcpa_pkg::OP_LOAD_C, 3'd0, 3'd0, 16'h8000, 16'd0));
        send(mk(wcpa_pkg::OP_COMMIT, 3'd0, 3'd0, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd0, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_COMMIT, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd0, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_READ, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd7, 16'd0, 16'd0));
        send(mk(OP_SPARE_6, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF));
        send(mk(OP_SPARE_7, 3'd0, 3'd0, 16'h8000, 16'h0001));
        send(mk(wcpa_pkg::OP_READ, 3'd7, 3'd0, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_CLEAR, 3'd0, 3'd0, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd0, 16'd0, 16'd0));
        // stores survive a clear
        send(mk(wcpa_pkg::OP_COMMIT, 3'd0, 3'd0, 16'd0, 16'd1));
        send(mk(wcpa_pkg::OP_READ, 3'd7, 3'd7, 16'd0, 16'd0));
        settle();
        write_reg(wcpa_pkg::CFG_CENTER, 4'd1);
        send(mk(wcpa_pkg::OP_COMMIT, 3'd0, 3'd0, 16'd0, 16'hFFFF));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd0, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_READ, 3'd0, 3'd7, 16'd0, 16'd0));
        send(mk(wcpa_pkg::OP_READ, 3'd7, 3'd0, 16'd0, 16'd0));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            if (p == 6)
            begin
                run_extremes();
                settle();
            end
            if (p == 4)
                write_reg(CFG_SPARE, 4'($urandom));
            if (p >= 8)
            begin
                write_reg(wcpa_pkg::CFG_ROWS, 4'($urandom_range(0, 15)));
                write_reg(wcpa_pkg::CFG_COLS, 4'($urandom_range(0, 15)));
                write_reg(wcpa_pkg::CFG_CENTER, 4'($urandom));
            end
            else
            begin
                write_reg(wcpa_pkg::CFG_ROWS, phase_rows[p]);
                write_reg(wcpa_pkg::CFG_COLS, phase_cols[p]);
                write_reg(wcpa_pkg::CFG_CENTER, phase_ctr[p]);
            end
            run_random(ITEMS_PER_PHASE);
        end

        settle();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
